// ===== rtl/core/rmt_pkg.sv =====
package rmt_pkg;

    localparam int ACT_W      = 4;   // action index
    localparam int AMT_W      = 32;  // signed Q16.16 amount
    localparam int CNT_W      = 5;   // action_count register
    localparam int REGRET_W   = 32;  // Q16.16 regret entry
    localparam int WEIGHT_W   = 48;  // Q32.16 strategy sum entry
    localparam int TOTAL_W    = 52;  // sum of up to sixteen weight entries
    localparam int SUM_W      = 56;  // serial adder word
    localparam int DIGIT_W    = 8;   // serial adder digit
    localparam int PROB_W     = 17;  // Q0.16 probability, one included
    localparam int MAX_ACTIVE = 16;  // ceiling on active actions

    localparam logic [PROB_W-1:0] PROB_ONE = 17'h10000;

    typedef enum logic [1:0] {
        OP_ADD_REGRET    = 2'd0,
        OP_ADD_WEIGHT    = 2'd1,
        OP_READ_STRATEGY = 2'd2,
        OP_READ_AVERAGE  = 2'd3
    } t_opcode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UPD_RD,
        S_UPD_GO,
        S_UPD_WAIT,
        S_SUM_RD,
        S_SUM_GO,
        S_SUM_WAIT,
        S_DIV_RD,
        S_DIV_GO,
        S_DIV_WAIT,
        S_OUT
    } t_state;

    // start request to one of the serial units
    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] a;
        logic [SUM_W-1:0] b;
    } t_add_req;

    typedef struct packed {
        logic               start;
        logic [TOTAL_W-1:0] num;
        logic [TOTAL_W-1:0] den;
    } t_div_req;

endpackage

// ===== rtl/core/regret_matching_table_core.sv =====
// Channel      Dir  Handshake               Payload
// s (request)  in   i_s_tvalid/o_s_tready   tuser: opcode; tdata: action_index, amount
// m (prob)     out  o_m_tvalid/i_m_tready   tdata: result_action, probability; tlast
// cfg          in   i_cfg_we                i_cfg_wdata: action_count
//
// Updates read the table, run a 7-digit serial add and write back.
// Queries for n active actions run a serial add per entry to form the total,
// then a bit-serial division per entry.
// Synchronous active-low reset clears the entry valid bits, so both tables
// read as zero; no clearing pass. A stalled output holds the divider back;
// the next request is taken once the last result of a run is registered.
module regret_matching_table_core
    import rmt_pkg::*;
#(
    parameter int MAX_ACTION_SLOTS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [39:0]      i_s_tdata,   // [3:0] action_index, [35:4] amount, rest zero
    input  logic [1:0]       i_s_tuser,   // [1:0] opcode
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [23:0]      o_m_tdata,   // [3:0] result_action, [20:4] probability
    output logic             o_m_tlast
);

    localparam int AW = $clog2(MAX_ACTION_SLOTS);

    t_state r_state;
    t_state n_state;

    logic [CNT_W-1:0]    r_action_count;
    t_opcode             r_op;
    logic [ACT_W-1:0]    r_idx;
    logic [AMT_W-1:0]    r_amt;
    logic [CNT_W-1:0]    r_n;
    logic [CNT_W-1:0]    r_i;
    logic [TOTAL_W-1:0]  r_total;
    logic [PROB_W-1:0]   r_prob;

    logic [REGRET_W-1:0] mem_regret [MAX_ACTION_SLOTS];
    logic [WEIGHT_W-1:0] mem_weight [MAX_ACTION_SLOTS];
    logic [MAX_ACTION_SLOTS-1:0] r_vld_regret;
    logic [MAX_ACTION_SLOTS-1:0] r_vld_weight;
    logic [REGRET_W-1:0] r_q_regret;
    logic [WEIGHT_W-1:0] r_q_weight;
    logic                r_qv_regret;
    logic                r_qv_weight;

    logic                r_m_tvalid;
    logic [ACT_W-1:0]    r_m_action;
    logic [PROB_W-1:0]   r_m_prob;
    logic                r_m_last;

    logic                accept;
    logic                in_range;
    logic                amt_pos;
    logic                upd_ok;
    logic [CNT_W-1:0]    n_clamped;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       wr_addr;
    logic [WEIGHT_W-1:0] entry;
    logic                last_i;
    logic                out_free;
    logic                wr_en;
    logic [REGRET_W-1:0] wr_regret;
    logic [WEIGHT_W-1:0] wr_weight;

    t_add_req            add_req;
    logic                add_done;
    logic [SUM_W-1:0]    add_sum;
    t_div_req            div_req;
    logic                div_done;
    logic [PROB_W-1:0]   div_quot;

    rmt_serial_add u_add (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (add_req),
        .o_done  (add_done),
        .o_sum   (add_sum)
    );

    rmt_serial_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign in_range   = 32'(i_s_tdata[3:0]) < MAX_ACTION_SLOTS;
    assign amt_pos    = !i_s_tdata[35] && (|i_s_tdata[34:4]);
    assign upd_ok     = in_range && (!i_s_tuser[0] || amt_pos);

    always_comb begin
        if (r_action_count == '0) begin
            n_clamped = CNT_W'(1);
        end else if (32'(r_action_count) > MAX_ACTIVE) begin
            n_clamped = CNT_W'(MAX_ACTIVE);
        end else begin
            n_clamped = r_action_count;
        end
        if (32'(n_clamped) > MAX_ACTION_SLOTS) begin
            n_clamped = CNT_W'(MAX_ACTION_SLOTS);
        end
    end

    assign rd_addr  = (r_state == S_UPD_RD) ? AW'(r_idx) : AW'(r_i);
    assign wr_addr  = AW'(r_idx);
    assign last_i   = (r_i == r_n - 1'b1);
    assign out_free = !r_m_tvalid || i_m_tready;

    // odd opcodes work on the weight table, even ones on the regret table
    always_comb begin
        if (r_op[0]) begin
            entry = r_qv_weight ? r_q_weight : '0;
        end else begin
            entry = r_qv_regret ? {{(WEIGHT_W-REGRET_W){1'b0}}, r_q_regret} : '0;
        end
    end

    always_comb begin
        add_req.start = (r_state == S_UPD_GO) || (r_state == S_SUM_GO);
        if (r_op[1]) begin
            add_req.a = {{(SUM_W-TOTAL_W){1'b0}}, r_total};
            add_req.b = {{(SUM_W-WEIGHT_W){1'b0}}, entry};
        end else begin
            add_req.a = {{(SUM_W-WEIGHT_W){1'b0}}, entry};
            add_req.b = {{(SUM_W-AMT_W){r_amt[AMT_W-1]}}, r_amt};
        end
        div_req.start = (r_state == S_DIV_GO);
        if (r_total == '0) begin
            div_req.num = TOTAL_W'(1);
            div_req.den = TOTAL_W'(r_n);
        end else begin
            div_req.num = {{(TOTAL_W-WEIGHT_W){1'b0}}, entry};
            div_req.den = r_total;
        end
    end

    // clamp of the updated entry
    always_comb begin
        if (add_sum[SUM_W-1]) begin
            wr_regret = '0;
        end else if (|add_sum[SUM_W-2:REGRET_W]) begin
            wr_regret = '1;
        end else begin
            wr_regret = add_sum[REGRET_W-1:0];
        end
        if (|add_sum[SUM_W-1:WEIGHT_W]) begin
            wr_weight = '1;
        end else begin
            wr_weight = add_sum[WEIGHT_W-1:0];
        end
    end

    assign wr_en = (r_state == S_UPD_WAIT) && add_done;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_s_tuser[1]) begin
                        n_state = S_SUM_RD;
                    end else if (upd_ok) begin
                        n_state = S_UPD_RD;
                    end
                end
            end
            S_UPD_RD:   n_state = S_UPD_GO;
            S_UPD_GO:   n_state = S_UPD_WAIT;
            S_UPD_WAIT: begin
                if (add_done) n_state = S_IDLE;
            end
            S_SUM_RD:   n_state = S_SUM_GO;
            S_SUM_GO:   n_state = S_SUM_WAIT;
            S_SUM_WAIT: begin
                if (add_done) n_state = last_i ? S_DIV_RD : S_SUM_RD;
            end
            S_DIV_RD:   n_state = S_DIV_GO;
            S_DIV_GO:   n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (div_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) n_state = last_i ? S_IDLE : S_DIV_RD;
            end
            default:    n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_action_count <= CNT_W'(MAX_ACTIVE);
        end else if (i_cfg_we) begin
            r_action_count <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= t_opcode'(i_s_tuser[1:0]);
            r_idx   <= i_s_tdata[3:0];
            r_amt   <= i_s_tdata[35:4];
            r_n     <= n_clamped;
            r_i     <= '0;
            r_total <= '0;
        end
        if ((r_state == S_SUM_WAIT) && add_done) begin
            r_total <= add_sum[TOTAL_W-1:0];
            r_i     <= last_i ? '0 : r_i + 1'b1;
        end
        if ((r_state == S_DIV_WAIT) && div_done) begin
            r_prob <= div_quot;
        end
        if ((r_state == S_OUT) && out_free) begin
            r_i <= r_i + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q_regret  <= mem_regret[rd_addr];
        r_q_weight  <= mem_weight[rd_addr];
        r_qv_regret <= r_vld_regret[rd_addr];
        r_qv_weight <= r_vld_weight[rd_addr];
        if (wr_en && !r_op[0]) begin
            mem_regret[wr_addr] <= wr_regret;
        end
        if (wr_en && r_op[0]) begin
            mem_weight[wr_addr] <= wr_weight;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_regret <= '0;
            r_vld_weight <= '0;
        end else if (wr_en) begin
            if (r_op[0]) begin
                r_vld_weight[wr_addr] <= 1'b1;
            end else begin
                r_vld_regret[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if ((r_state == S_OUT) && out_free) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && out_free) begin
            r_m_action <= r_i[ACT_W-1:0];
            r_m_prob   <= r_prob;
            r_m_last   <= last_i;
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = {3'b000, r_m_prob, r_m_action};
    assign o_m_tlast  = r_m_last;

    a_add_done_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        add_done |-> (r_state == S_UPD_WAIT || r_state == S_SUM_WAIT))
        else $error("serial add finished outside a wait state");

    a_div_done_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV_WAIT))
        else $error("divider finished outside its wait state");

    a_prob_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (r_m_prob <= PROB_ONE))
        else $error("probability above one");

    a_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (r_i < r_n))
        else $error("result index past active count");

    a_weight_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && r_op == OP_ADD_WEIGHT) |-> !add_sum[SUM_W-1])
        else $error("weight sum went negative");

endmodule

// ===== rtl/core/rmt_serial_add.sv =====
module rmt_serial_add
    import rmt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_add_req         i_req,
    output logic             o_done,
    output logic [SUM_W-1:0] o_sum
);

    localparam int DIGITS = SUM_W / DIGIT_W;
    localparam int DC_W   = $clog2(DIGITS);

    logic [SUM_W-1:0]   r_a;
    logic [SUM_W-1:0]   r_b;
    logic [SUM_W-1:0]   r_s;
    logic               r_c;
    logic [DC_W-1:0]    r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [DIGIT_W:0]   digit_sum;

    assign digit_sum = {1'b0, r_a[DIGIT_W-1:0]} + {1'b0, r_b[DIGIT_W-1:0]}
                     + {{DIGIT_W{1'b0}}, r_c};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DC_W'(DIGITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // low digit first; result digits enter at the top
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a <= i_req.a;
            r_b <= i_req.b;
            r_c <= 1'b0;
        end else if (r_busy) begin
            r_a <= r_a >> DIGIT_W;
            r_b <= r_b >> DIGIT_W;
            r_c <= digit_sum[DIGIT_W];
            r_s <= {digit_sum[DIGIT_W-1:0], r_s[SUM_W-1:DIGIT_W]};
        end
    end

    assign o_done = r_done;
    assign o_sum  = r_s;

endmodule

// ===== rtl/core/rmt_serial_div.sv =====
module rmt_serial_div
    import rmt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_div_req          i_req,
    output logic              o_done,
    output logic [PROB_W-1:0] o_quot
);

    // quotient of num * 2^16 / den, num <= den, one bit per cycle
    localparam int SC_W = $clog2(PROB_W);

    logic [TOTAL_W:0]   r_rem;
    logic [TOTAL_W-1:0] r_den;
    logic [PROB_W-1:0]  r_q;
    logic [SC_W-1:0]    r_step;
    logic               r_busy;
    logic               r_done;
    logic [TOTAL_W:0]   shifted;
    logic               ge;

    assign shifted = (r_step == '0) ? r_rem : {r_rem[TOTAL_W-1:0], 1'b0};
    assign ge      = shifted >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == SC_W'(PROB_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= {1'b0, i_req.num};
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= ge ? (shifted - {1'b0, r_den}) : shifted;
            r_q   <= {r_q[PROB_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule
